>>> design/point_line_distance_core_assert.svh
// Assertion macros used by the distance core.
`ifndef POINT_LINE_DISTANCE_CORE_ASSERT_SVH
`define POINT_LINE_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pld_pkg.sv
`default_nettype none
package pld_pkg;
  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int CSQ_W      = 2 * CROSS_W;
  localparam int LEN_W      = PROD_W + 2;
  localparam int SUM_W      = CSQ_W + 2;
  localparam int DIST_BITS  = 25;
  localparam int QUO_W      = 2 * DIST_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int HEAD_W     = SUM_W - (QUO_W - FRAC_BITS);
  localparam int RREM_W     = DIST_BITS + 2;

  typedef enum logic {
    OP_2D = 1'b0,
    OP_3D = 1'b1
  } opcode_t;
endpackage
`default_nettype wire

>>> design/point_line_distance_core.sv
// Perpendicular distance from query point P to the line through A and B.
// Input channel: in_valid / in_stall with opcode (2D or 3D) and nine signed
// Q8.8 coordinates. Result channel: out_valid / out_stall with the distance
// (unsigned, 16 fraction bits, truncated) and a flag for coincident A and B.
// One transaction is accepted per cycle while in_stall is low. The pipeline
// consists of the 50-stage restoring divider (one quotient bit per stage)
// and the 25-stage square root (one root bit per stage) behind a four-stage
// front end of differences, products and squares.
// The whole pipeline advances as one: while a result waits at the output
// under out_stall, in_stall is high and every stage holds its contents.
// Reset (rst_n low, synchronous) empties all stages; no result is produced
// until new input arrives.
`default_nettype none
module point_line_distance_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_opcode,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_ax,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_ay,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_az,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_bx,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_by_coord,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_bz,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_px,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_py,
  input  wire  [pld_pkg::FIELD_BITS-1:0] in_pz,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [pld_pkg::DIST_BITS-1:0] out_distance_out,
  output logic                         out_degenerate
);
  import pld_pkg::*;
  `include "point_line_distance_core_assert.svh"

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: coordinate differences.
  logic                     v1_r;
  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [DIFF_W-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;

  function automatic logic signed [DIFF_W-1:0] sub_c(input logic [FIELD_BITS-1:0] a,
                                                      input logic [FIELD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] ea, eb;
    ea = $signed({a[COORD_BITS-1], a[COORD_BITS-1:0]});
    eb = $signed({b[COORD_BITS-1], b[COORD_BITS-1:0]});
    return ea - eb;
  endfunction

  always_comb begin
    ux_nxt = sub_c(in_bx, in_ax);
    uy_nxt = sub_c(in_by_coord, in_ay);
    vx_nxt = sub_c(in_px, in_ax);
    vy_nxt = sub_c(in_py, in_ay);
    uz_nxt = (opcode_t'(in_opcode) == OP_3D) ? sub_c(in_bz, in_az) : '0;
    vz_nxt = (opcode_t'(in_opcode) == OP_3D) ? sub_c(in_pz, in_az) : '0;
  end

  // Stage 2: cross-product terms and squared components of AB.
  logic                     v2_r;
  logic signed [PROD_W-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [PROD_W-1:0] sq_x_r, sq_y_r, sq_z_r;

  // Stage 3: cross product and squared length.
  logic                      v3_r;
  logic signed [CROSS_W-1:0] kx_r, ky_r, kz_r;
  logic        [LEN_W-1:0]   len3_r;

  // Stage 4: squared cross components.
  logic                    v4_r;
  logic [CSQ_W-1:0]        kxx_r, kyy_r, kzz_r;
  logic [LEN_W-1:0]        len4_r;
  logic signed [CSQ_W-1:0] kxx_s, kyy_s, kzz_s;

  assign kxx_s = kx_r * kx_r;
  assign kyy_s = ky_r * ky_r;
  assign kzz_s = kz_r * kz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      uz_r   <= uz_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      vz_r   <= vz_nxt;
      p_yz_r <= uy_r * vz_r;
      p_zy_r <= uz_r * vy_r;
      p_zx_r <= uz_r * vx_r;
      p_xz_r <= ux_r * vz_r;
      p_xy_r <= ux_r * vy_r;
      p_yx_r <= uy_r * vx_r;
      sq_x_r <= ux_r * ux_r;
      sq_y_r <= uy_r * uy_r;
      sq_z_r <= uz_r * uz_r;
      kx_r   <= CROSS_W'(p_yz_r) - CROSS_W'(p_zy_r);
      ky_r   <= CROSS_W'(p_zx_r) - CROSS_W'(p_xz_r);
      kz_r   <= CROSS_W'(p_xy_r) - CROSS_W'(p_yx_r);
      len3_r <= LEN_W'($unsigned(sq_x_r)) + LEN_W'($unsigned(sq_y_r))
              + LEN_W'($unsigned(sq_z_r));
      kxx_r  <= $unsigned(kxx_s);
      kyy_r  <= $unsigned(kyy_s);
      kzz_r  <= $unsigned(kzz_s);
      len4_r <= len3_r;
    end
  end

  // Divider: numerator is the cross sum shifted up by FRAC_BITS. The bits
  // above the quotient width form the starting remainder; if that already
  // reaches the divisor, the quotient cannot fit and the result saturates.
  logic [SUM_W-1:0]  csum;
  logic [HEAD_W-1:0] head;
  assign csum = SUM_W'(kxx_r) + SUM_W'(kyy_r) + SUM_W'(kzz_r);
  assign head = csum[SUM_W-1:QUO_W-FRAC_BITS];

  logic             dv_r   [QUO_W+1];
  logic [LEN_W-1:0] drem_r [QUO_W+1];
  logic [QUO_W-1:0] dnq_r  [QUO_W+1];
  logic [LEN_W-1:0] dlen_r [QUO_W+1];
  logic             ddeg_r [QUO_W+1];
  logic             dsat_r [QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ddeg_r[0] <= (len4_r == '0);
      dsat_r[0] <= (head >= HEAD_W'(len4_r));
      drem_r[0] <= (head >= HEAD_W'(len4_r)) ? '0 : LEN_W'(head);
      dnq_r[0]  <= {csum[QUO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      dlen_r[0] <= len4_r;
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    logic [LEN_W:0]   trial;
    logic             take;
    logic [LEN_W-1:0] rem_nxt;
    always_comb begin
      trial   = {drem_r[i], dnq_r[i][QUO_W-1]};
      take    = (trial >= {1'b0, dlen_r[i]});
      rem_nxt = take ? LEN_W'(trial - {1'b0, dlen_r[i]}) : trial[LEN_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (adv) begin
        dv_r[i+1] <= dv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[i+1] <= rem_nxt;
        dnq_r[i+1]  <= {dnq_r[i][QUO_W-2:0], take};
        dlen_r[i+1] <= dlen_r[i];
        ddeg_r[i+1] <= ddeg_r[i];
        dsat_r[i+1] <= dsat_r[i];
      end
    end
  end

  // Square root, one root bit per stage from two quotient bits.
  logic                 sv_r   [DIST_BITS+1];
  logic [QUO_W-1:0]     sq_r   [DIST_BITS+1];
  logic [RREM_W-1:0]    srem_r [DIST_BITS+1];
  logic [DIST_BITS-1:0] sroot_r[DIST_BITS+1];
  logic                 sdeg_r [DIST_BITS+1];
  logic                 ssat_r [DIST_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= dv_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0]    <= dnq_r[QUO_W];
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sdeg_r[0]  <= ddeg_r[QUO_W];
      ssat_r[0]  <= dsat_r[QUO_W];
    end
  end

  for (genvar j = 0; j < DIST_BITS; j++) begin : g_sqrt
    logic [RREM_W+1:0] acc;
    logic [RREM_W+1:0] tst;
    logic              take;
    always_comb begin
      acc  = {srem_r[j], sq_r[j][QUO_W-1 -: 2]};
      tst  = (RREM_W+2)'({sroot_r[j], 2'b01});
      take = (acc >= tst);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else if (adv) begin
        sv_r[j+1] <= sv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        srem_r[j+1]  <= take ? RREM_W'(acc - tst) : RREM_W'(acc);
        sroot_r[j+1] <= {sroot_r[j][DIST_BITS-2:0], take};
        sq_r[j+1]    <= {sq_r[j][QUO_W-3:0], 2'b00};
        sdeg_r[j+1]  <= sdeg_r[j];
        ssat_r[j+1]  <= ssat_r[j];
      end
    end
  end

  // Output register.
  logic                 out_valid_r;
  logic [DIST_BITS-1:0] dist_r;
  logic                 deg_r;
  logic                 sat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r[DIST_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r     <= sdeg_r[DIST_BITS];
      sat_out_r <= ssat_r[DIST_BITS] && !sdeg_r[DIST_BITS];
      if (sdeg_r[DIST_BITS]) begin
        dist_r <= '0;
      end else if (ssat_r[DIST_BITS]) begin
        dist_r <= '1;
      end else begin
        dist_r <= sroot_r[DIST_BITS];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance_out = dist_r;
  assign out_degenerate   = deg_r;

  `PLD_ASSERT_NEXT(a_enter, in_valid && !in_stall, v1_r, "accepted transaction not captured")
  `PLD_ASSERT_NOW(a_div_rem, dv_r[QUO_W] && !dsat_r[QUO_W] && !ddeg_r[QUO_W], drem_r[QUO_W] < dlen_r[QUO_W], "divider remainder not below divisor")
  `PLD_ASSERT_NOW(a_sqrt_rem, sv_r[DIST_BITS] && !ssat_r[DIST_BITS], srem_r[DIST_BITS] <= RREM_W'({sroot_r[DIST_BITS], 1'b0}), "square root remainder too large")
  `PLD_ASSERT_NOW(a_deg_zero, out_valid && out_degenerate, out_distance_out == '0, "degenerate result with nonzero distance")
  `PLD_ASSERT_NOW(a_sat_ones, out_valid && sat_out_r, out_distance_out == '1, "saturated result not all ones")
endmodule
`default_nettype wire
